>>> sv/chp_pkg.sv
// Types and constants shared by the column histogram peak search.
// Holds the request and result payload structs, the register indexes and the
// sequencer state type. Depends on nothing else.
package chp_pkg;

    localparam int PIXEL_BITS     = 8;
    localparam int CFG_BITS       = 12;
    localparam int CFG_INDEX_BITS = 2;
    localparam int COL_OUT_BITS   = 11;
    localparam int COUNT_OUT_BITS = 12;
    // Wide enough to hold any frame width and the column limit itself.
    localparam int WIDTH_EXT_BITS = 13;

    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPLIT_COLUMN = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MATCH_VALUE  = 2'd2;

    localparam logic [CFG_BITS-1:0]   FRAME_WIDTH_RESET  = 12'd1920;
    localparam logic [CFG_BITS-1:0]   SPLIT_COLUMN_RESET = 12'd960;
    localparam logic [PIXEL_BITS-1:0] MATCH_VALUE_RESET  = 8'd255;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] pixel_value;
        logic                  frame_end;
    } t_pixel_req;

    typedef struct packed {
        logic [COL_OUT_BITS-1:0]   left_column;
        logic [COUNT_OUT_BITS-1:0] left_count;
        logic                      left_found;
        logic [COL_OUT_BITS-1:0]   right_column;
        logic [COUNT_OUT_BITS-1:0] right_count;
        logic                      right_found;
    } t_peak_result;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_UPDATE,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } t_state;

endpackage

>>> sv/column_histogram_peaks.sv
// Column histogram peak search: per-column match counts in one memory and a
// sequencer that updates, scans and clears them. Depends on chp_pkg.
//
// Use: pixels arrive on the input channel (valid/ready) in raster order, one
// request each, with frame_end set on the last pixel of a frame. The cycle a
// pixel is accepted reads its column's count, the next writes the incremented
// count back, for a matching pixel only, through the separate write port.
// The pixel marked frame_end is counted, then all MAX_COLUMNS counts are read
// one per cycle, compared against the running left and right peaks and
// cleared behind the read. After a drain state, the done state loads the
// result into the output register, and input is accepted again from the cycle
// in which the result appears on the output channel. The result sits in
// an output register; if the receiver stalls, the next frame is taken in
// meanwhile, and only the load of its own result waits until it is free.
// After reset a clearing pass writes zero to every memory entry, one per
// cycle; no pixel is accepted during it, but register writes are taken at
// any time and are meant to be made while idle.
module column_histogram_peaks #(
    parameter int MAX_COLUMNS = 2048,
    parameter int COUNT_BITS  = 12
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [chp_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [chp_pkg::CFG_BITS-1:0]       i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  chp_pkg::t_pixel_req                i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output chp_pkg::t_peak_result              o_out_data
);
    import chp_pkg::*;

    localparam int AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam logic [AW-1:0]             LAST_COL  = AW'(MAX_COLUMNS - 1);
    localparam logic [COUNT_BITS-1:0]     COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [WIDTH_EXT_BITS-1:0] MAX_WIDTH = WIDTH_EXT_BITS'(MAX_COLUMNS);

    logic [COUNT_BITS-1:0] r_mem [MAX_COLUMNS];

    t_state r_state, n_state;

    logic [CFG_BITS-1:0]   r_frame_width;
    logic [CFG_BITS-1:0]   r_split_column;
    logic [PIXEL_BITS-1:0] r_match_value;

    logic [AW-1:0]         r_pos;
    logic [AW-1:0]         r_addr;
    logic                  r_match;
    logic                  r_last;
    logic [AW-1:0]         r_idx;
    logic [COUNT_BITS-1:0] r_rd_data;
    logic                  r_cmp_valid;
    logic [AW-1:0]         r_cmp_idx;
    logic [COUNT_BITS-1:0] r_best_left, r_best_right;
    logic [AW-1:0]         r_where_left, r_where_right;
    logic                  r_out_valid;
    t_peak_result          r_out_data;

    logic                  in_accept;
    logic                  mem_we;
    logic [AW-1:0]         mem_wa;
    logic [COUNT_BITS-1:0] mem_wd;
    logic [AW-1:0]         mem_ra;
    logic                  load_out;
    logic                  scan_start;

    logic [WIDTH_EXT_BITS-1:0] eff_width;
    logic [WIDTH_EXT_BITS-1:0] next_pos;
    logic                      cmp_right;
    logic [COUNT_BITS-1:0]     inc_count;

    assign in_accept = i_in_valid && o_in_ready;

    // A width of zero acts as one; one beyond the store acts as the store size.
    always_comb begin
        if (r_frame_width == '0) begin
            eff_width = WIDTH_EXT_BITS'(1);
        end else if (WIDTH_EXT_BITS'(r_frame_width) > MAX_WIDTH) begin
            eff_width = MAX_WIDTH;
        end else begin
            eff_width = WIDTH_EXT_BITS'(r_frame_width);
        end
    end

    assign next_pos  = WIDTH_EXT_BITS'(r_pos) + WIDTH_EXT_BITS'(1);
    assign cmp_right = WIDTH_EXT_BITS'(r_cmp_idx) >= WIDTH_EXT_BITS'(r_split_column);
    assign inc_count = (r_rd_data == COUNT_MAX) ? r_rd_data : r_rd_data + 1'b1;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR:  if (r_idx == LAST_COL) n_state = S_IDLE;
            S_IDLE:   if (i_in_valid) n_state = S_UPDATE;
            S_UPDATE: n_state = r_last ? S_SCAN : S_IDLE;
            S_SCAN:   if (r_idx == LAST_COL) n_state = S_DRAIN;
            S_DRAIN:  n_state = S_DONE;
            S_DONE:   if (!r_out_valid || i_out_ready) n_state = S_IDLE;
            default:  n_state = S_CLEAR;
        endcase
    end

    // Sequencer outputs and memory port control.
    always_comb begin
        o_in_ready = 1'b0;
        mem_we     = 1'b0;
        mem_wa     = r_idx;
        mem_wd     = '0;
        mem_ra     = r_idx;
        load_out   = 1'b0;
        scan_start = 1'b0;
        case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                mem_ra     = r_pos;
            end
            S_UPDATE: begin
                mem_we     = r_match;
                mem_wa     = r_addr;
                mem_wd     = inc_count;
                scan_start = r_last;
            end
            S_SCAN: begin
                // The read returns the old count while zero is written behind it.
                mem_we = 1'b1;
            end
            S_DRAIN: begin
            end
            S_DONE: begin
                load_out = !r_out_valid || i_out_ready;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RESET;
            r_split_column <= SPLIT_COLUMN_RESET;
            r_match_value  <= MATCH_VALUE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                REG_SPLIT_COLUMN: r_split_column <= i_cfg_data;
                REG_MATCH_VALUE:  r_match_value  <= i_cfg_data[PIXEL_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_pos       <= '0;
            r_idx       <= '0;
            r_last      <= 1'b0;
            r_match     <= 1'b0;
            r_cmp_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cmp_valid <= (r_state == S_SCAN);
            r_cmp_idx   <= r_idx;

            if (r_state == S_CLEAR || r_state == S_SCAN) begin
                r_idx <= (r_idx == LAST_COL) ? '0 : r_idx + 1'b1;
            end

            if (in_accept) begin
                r_addr  <= r_pos;
                r_match <= (i_in_data.pixel_value == r_match_value);
                r_last  <= i_in_data.frame_end;
                if (i_in_data.frame_end || next_pos >= eff_width) begin
                    r_pos <= '0;
                end else begin
                    r_pos <= next_pos[AW-1:0];
                end
            end

            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Running peaks: a strict compare keeps the lower column on a tie.
    always_ff @(posedge i_clk) begin
        if (scan_start) begin
            r_best_left   <= '0;
            r_best_right  <= '0;
            r_where_left  <= '0;
            r_where_right <= '0;
        end else if (r_cmp_valid) begin
            if (cmp_right) begin
                if (r_rd_data > r_best_right) begin
                    r_best_right  <= r_rd_data;
                    r_where_right <= r_cmp_idx;
                end
            end else if (r_rd_data > r_best_left) begin
                r_best_left  <= r_rd_data;
                r_where_left <= r_cmp_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_data.left_column  <= COL_OUT_BITS'(r_where_left);
            r_out_data.left_count   <= COUNT_OUT_BITS'(r_best_left);
            r_out_data.left_found   <= (r_best_left != '0);
            r_out_data.right_column <= COL_OUT_BITS'(r_where_right);
            r_out_data.right_count  <= COUNT_OUT_BITS'(r_best_right);
            r_out_data.right_found  <= (r_best_right != '0);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
